### sv/lqm_pkg.sv
// ----------------------------------------------------------------------------
// lqm_pkg
// Shared types and codes for the lock queue manager: request and result
// words, status and notice codes, sequencer states and control signals.
// ----------------------------------------------------------------------------
package lqm_pkg;

    // Field widths of the request and result words.
    localparam int unsigned LOCK_NUM_W   = 6;
    localparam int unsigned CLIENT_NUM_W = 8;
    localparam int unsigned LOCK_CODES   = 2 ** LOCK_NUM_W;

    // Request kinds.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_QUEUED  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Notice kinds.
    localparam logic [1:0] NK_NONE   = 2'd0;
    localparam logic [1:0] NK_REVOKE = 2'd1;
    localparam logic [1:0] NK_RETRY  = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [LOCK_NUM_W-1:0]   lock_num;
        logic [CLIENT_NUM_W-1:0] client_num;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [1:0]              notify_kind;
        logic [CLIENT_NUM_W-1:0] notify_client;
    } rsp_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_PTR,
        FSM_OUT
    } fsm_t;

    typedef struct packed {
        logic busy;
        logic clearing;
        logic update;
        logic result_valid;
    } ctl_t;

endpackage

### sv/lqm_ram.sv
// ----------------------------------------------------------------------------
// lqm_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lqm_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 8,
    parameter int unsigned AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lqm_ctl.sv
// ----------------------------------------------------------------------------
// lqm_ctl
// Request sequencer: clearing sweep of the pointer memory after reset, then
// a two-step round per request (pointer update, then result).
// ----------------------------------------------------------------------------
module lqm_ctl #(
    parameter int unsigned NUM_LOCKS = 64,
    parameter int unsigned LW        = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output lqm_pkg::ctl_t ctl,
    output logic [LW-1:0] clr_addr
);

    import lqm_pkg::*;

    localparam logic [LW-1:0] LAST_LOCK = LW'(NUM_LOCKS - 1);

    fsm_t          state_reg;
    fsm_t          state_next;
    logic [LW-1:0] clr_addr_reg;
    logic [LW-1:0] clr_addr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + LW'(1);
                if (clr_addr_reg == LAST_LOCK)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE, FSM_OUT:
            begin
                state_next = start ? FSM_PTR : FSM_IDLE;
            end
            FSM_PTR:
            begin
                state_next = FSM_OUT;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                ctl.busy     = 1'b1;
                ctl.clearing = 1'b1;
            end
            FSM_IDLE:
            begin
                ctl = '0;
            end
            FSM_PTR:
            begin
                ctl.busy   = 1'b1;
                ctl.update = 1'b1;
            end
            FSM_OUT:
            begin
                ctl.result_valid = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign clr_addr = clr_addr_reg;

endmodule

### sv/lock_queue_manager.sv
// ----------------------------------------------------------------------------
// lock_queue_manager
// Lock manager with one FIFO wait queue of client numbers per lock.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Exactly one
// result word follows for every request: it sits on result for one cycle,
// flagged by result_valid, in the output state that follows the pointer
// state, and the receiver cannot hold it off. In the cycle that shows a
// result, busy is already low, so a new request can be taken there; busy is
// high in the pointer state, since the read-modify-write round on the
// pointer memory must finish first (the lock's head and count are read,
// then the round decides, writes back and reads the queue entry that the
// notice names). After reset, busy stays high while every lock's pointer
// word is cleared to an empty queue.
//
// Storage is held in two synchronous RAMs. The pointer RAM keeps one word
// per lock with the slot of the queue head and the number of queued
// clients. The entry RAM keeps QUEUE_DEPTH client numbers per lock as a
// circular buffer. Because a request's write-back completes before the next
// request's pointer read, no forwarding is needed. The entry RAM is never
// cleared, since only occupied slots are ever shown in a result.
//
// An acquire appends the client. It is granted on an empty queue, otherwise
// a revoke notice names the client that was last in the queue before the
// append. An acquire on a full queue is rejected and nothing changes. A
// release pops the head regardless of the client number, and a retry notice
// names the new head if the queue is still not empty. A release on an empty
// queue reports its own status. Lock numbers wrap modulo NUM_LOCKS.
// ----------------------------------------------------------------------------
module lock_queue_manager #(
    parameter int unsigned NUM_LOCKS   = 64,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lqm_pkg::req_t request,
    output logic          result_valid,
    output lqm_pkg::rsp_t result
);

    import lqm_pkg::*;

    // Lock index, head slot, count, sum, pointer word and entry address widths.
    localparam int unsigned LW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int unsigned PW   = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW   = PW + 1;
    localparam int unsigned PTRW = PW + CW;
    localparam int unsigned EAW  = $clog2(NUM_LOCKS * QUEUE_DEPTH);

    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // Brings a position below twice the depth back into the ring.
    function automatic logic [PW-1:0] wrap_pos(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        begin
            d = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
            wrap_pos = d[PW-1:0];
        end
    endfunction

    // Table that folds every lock code onto the locks that exist.
    logic [LW-1:0] wrap_tab [LOCK_CODES];

    for (genvar g = 0; g < LOCK_CODES; g++)
    begin : g_wrap
        localparam int unsigned WRAPPED = g % NUM_LOCKS;
        assign wrap_tab[g] = WRAPPED[LW-1:0];
    end

    ctl_t          ctl;
    logic [LW-1:0] clr_addr;
    logic          accept;
    logic [LW-1:0] lock_idx;

    // Request fields held for the round.
    logic                    req_type_reg;
    logic [LW-1:0]           lock_reg;
    logic [EAW-1:0]          base_reg;
    logic [CLIENT_NUM_W-1:0] client_reg;

    // Pointer RAM ports.
    logic            ptr_we;
    logic [LW-1:0]   ptr_waddr;
    logic [PTRW-1:0] ptr_wdata;
    logic [PTRW-1:0] ptr_rdata;

    // Entry RAM ports.
    logic                    ent_we;
    logic [EAW-1:0]          ent_waddr;
    logic [EAW-1:0]          ent_raddr;
    logic [CLIENT_NUM_W-1:0] ent_rdata;

    // Decision for the current round.
    logic [PW-1:0]   head;
    logic [CW-1:0]   count;
    logic [SW-1:0]   sum_tail;
    logic [PW-1:0]   tail_pos;
    logic [PW-1:0]   last_pos;
    logic [PW-1:0]   next_head;
    logic            upd_ptr;
    logic [PTRW-1:0] upd_word;
    logic            upd_ent;
    logic [PW-1:0]   rd_pos;
    logic [1:0]      status_next;
    logic [1:0]      kind_next;
    logic [1:0]      status_reg;
    logic [1:0]      kind_reg;

    lqm_ctl #(
        .NUM_LOCKS (NUM_LOCKS),
        .LW        (LW)
    ) u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .ctl      (ctl),
        .clr_addr (clr_addr)
    );

    assign busy     = ctl.busy;
    assign accept   = start & ~ctl.busy;
    assign lock_idx = wrap_tab[request.lock_num];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= request.req_type;
            lock_reg     <= lock_idx;
            base_reg     <= EAW'(lock_idx) * EAW'(QUEUE_DEPTH);
            client_reg   <= request.client_num;
        end
    end

    // Pointer word of the lock: head slot above, count below.
    assign head      = ptr_rdata[PTRW-1:CW];
    assign count     = ptr_rdata[CW-1:0];
    assign sum_tail  = SW'(head) + SW'(count);
    assign tail_pos  = wrap_pos(sum_tail);
    assign last_pos  = wrap_pos(sum_tail - SW'(1));
    assign next_head = wrap_pos(SW'(head) + SW'(1));

    always_comb
    begin
        upd_ptr     = 1'b0;
        upd_word    = ptr_rdata;
        upd_ent     = 1'b0;
        rd_pos      = next_head;
        status_next = ST_GRANTED;
        kind_next   = NK_NONE;
        if (req_type_reg == REQ_ACQUIRE)
        begin
            rd_pos = last_pos;
            if (count >= DEPTH_C)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                upd_ptr  = 1'b1;
                upd_ent  = 1'b1;
                upd_word = {head, count + CW'(1)};
                if (count != '0)
                begin
                    status_next = ST_QUEUED;
                    kind_next   = NK_REVOKE;
                end
            end
        end
        else
        begin
            if (count == '0)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                upd_ptr  = 1'b1;
                upd_word = {next_head, count - CW'(1)};
                if (count != CW'(1))
                begin
                    kind_next = NK_RETRY;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
        end
    end

    // The clearing sweep owns the pointer RAM write port until it ends.
    assign ptr_we    = ctl.clearing | (ctl.update & upd_ptr);
    assign ptr_waddr = ctl.clearing ? clr_addr : lock_reg;
    assign ptr_wdata = ctl.clearing ? '0 : upd_word;

    lqm_ram #(
        .DEPTH (NUM_LOCKS),
        .WIDTH (PTRW),
        .AW    (LW)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .re    (accept),
        .raddr (lock_idx),
        .rdata (ptr_rdata)
    );

    // An append writes the tail slot while the notice reads another slot.
    assign ent_we    = ctl.update & upd_ent;
    assign ent_waddr = base_reg + EAW'(tail_pos);
    assign ent_raddr = base_reg + EAW'(rd_pos);

    lqm_ram #(
        .DEPTH (NUM_LOCKS * QUEUE_DEPTH),
        .WIDTH (CLIENT_NUM_W),
        .AW    (EAW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (client_reg),
        .re    (ctl.update),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign result_valid         = ctl.result_valid;
    assign result.status        = status_reg;
    assign result.notify_kind   = kind_reg;
    assign result.notify_client = (kind_reg == NK_NONE) ? '0 : ent_rdata;

endmodule
